### hw/rtl/spn_block_cipher_table_driven_assert.svh
// Assertion macros shared by the SPN cipher checker.
// Needs only the assertion syntax of the language.
`ifndef SPN_BLOCK_CIPHER_TABLE_DRIVEN_ASSERT_SVH
`define SPN_BLOCK_CIPHER_TABLE_DRIVEN_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SPN_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define SPN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/spn_pkg.sv
// Shared types, constants and GF(2^8) helper for the SPN block cipher.
// No dependencies.
package spn_pkg;

   localparam int BLOCK_BYTES_DEF = 4;
   localparam int MAX_ROUNDS_DEF  = 10;

   localparam int REQ_TDATA_W = 48;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 32;
   localparam int PLAIN_W     = 32;
   localparam int ROUNDS_W    = 4;

   localparam logic [ROUNDS_W-1:0] RESET_ROUNDS = 4'd10;
   localparam logic [7:0]          GF_POLY      = 8'h1B;

   typedef enum logic [REQ_TUSER_W-1:0] {
      OP_SBOX    = 2'd0,
      OP_MATRIX  = 2'd1,
      OP_KEY     = 2'd2,
      OP_ENCRYPT = 2'd3
   } op_type;

   typedef struct packed {
      logic       en;
      logic [7:0] index;
      logic [7:0] data;
   } mat_wr_type;

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] aa;
      acc = 8'h00;
      aa  = a;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) begin
            acc = acc ^ aa;
         end
         aa = aa[7] ? ({aa[6:0], 1'b0} ^ GF_POLY) : {aa[6:0], 1'b0};
      end
      return acc;
   endfunction

endpackage

### hw/rtl/spn_ram.sv
// Single-port-write, single-port-read synchronous RAM, registered read data.
// Used for the S-box and round-key stores; no dependencies.
module spn_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/spn_mix.sv
// Mixing matrix registers and the GF(2^8) matrix-vector product plus key add.
// Depends on spn_pkg for gf_mul and the matrix write struct.
module spn_mix
   import spn_pkg::*;
#(
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
   input  logic                        clock,
   input  mat_wr_type                  mat_wr,
   input  logic [BLOCK_BYTES-1:0][7:0] sub_bytes,
   input  logic [BLOCK_BYTES-1:0][7:0] key_bytes,
   output logic [BLOCK_BYTES-1:0][7:0] mix_bytes
);

   localparam int MAT_DEPTH = BLOCK_BYTES * BLOCK_BYTES;

   logic [7:0] mat_ff [MAT_DEPTH];

   always_ff @(posedge clock) begin
      for (int e = 0; e < MAT_DEPTH; e++) begin
         if (mat_wr.en && (mat_wr.index == 8'(e))) begin
            mat_ff[e] <= mat_wr.data;
         end
      end
   end

   always_comb begin
      logic [7:0] acc;
      for (int i = 0; i < BLOCK_BYTES; i++) begin
         acc = key_bytes[i];
         for (int j = 0; j < BLOCK_BYTES; j++) begin
            acc = acc ^ gf_mul(mat_ff[i*BLOCK_BYTES + j], sub_bytes[j]);
         end
         mix_bytes[i] = acc;
      end
   end

endmodule

### hw/rtl/spn_block_cipher_table_driven.sv
// Each encrypt transfer runs R+1 passes before rsp_tvalid, R = rounds used (capped at MAX_ROUNDS);
// each pass fetches one S-box byte and one key byte a cycle, then mixes (the first only adds the key).
// A new encrypt or table write is accepted only in idle, after the previous result is loaded.
// Reset: synchronous; clears control and output valid, rounds register returns to 10.
// Table contents are undefined after reset until written.
module spn_block_cipher_table_driven
   import spn_pkg::*;
#(
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
   parameter int MAX_ROUNDS  = MAX_ROUNDS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // config: rounds_in_use
   input  logic                   csr_we,
   input  logic [ROUNDS_W-1:0]    csr_wdata,
   // tdata: table_index[7:0], table_byte[15:8], plain_block[47:16]
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // tuser: operation[1:0]
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   // tdata: cipher_block[31:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int BW        = BLOCK_BYTES * 8;
   localparam int KEY_DEPTH = BLOCK_BYTES * (MAX_ROUNDS + 1);
   localparam int KAW       = $clog2(KEY_DEPTH);
   localparam int CW        = $clog2(BLOCK_BYTES + 1);
   localparam int LW        = $clog2(BLOCK_BYTES);
   localparam int RW        = $clog2(MAX_ROUNDS + 1);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_FETCH = 3'b010,
      ST_MIX   = 3'b100
   } state_type;

   typedef logic [BLOCK_BYTES-1:0][7:0] blk_type;

   state_type             state_ff, state_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [RW-1:0]         rnd_ff, rnd_in;
   logic [KAW-1:0]        key_base_ff, key_base_in;
   logic                  cap_ff, cap_in;
   logic [LW-1:0]         lane_ff, lane_in;
   logic [ROUNDS_W-1:0]   rounds_ff, rounds_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   blk_type               blk_ff, blk_in;
   blk_type               sub_ff, sub_in;
   blk_type               keyb_ff, keyb_in;

   logic                  req_accept;
   op_type                req_op;
   logic [7:0]            req_index;
   logic [7:0]            req_byte;
   logic [PLAIN_W-1:0]    req_plain;
   logic [BW+PLAIN_W-1:0] plain_ext;
   logic [BW+RSP_TDATA_W-1:0] res_ext;
   logic [RW-1:0]         rounds_eff;
   blk_type               mix_bytes;
   blk_type               round_out;
   logic                  rsp_load;

   logic                  sbox_we;
   logic                  sbox_re;
   logic [7:0]            sbox_rdata;
   logic                  key_we;
   logic                  key_re;
   logic [KAW-1:0]        key_raddr;
   logic [7:0]            key_rdata;
   mat_wr_type            mat_wr;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_op     = op_type'(req_tuser);
   assign req_index  = req_tdata[7:0];
   assign req_byte   = req_tdata[15:8];
   assign req_plain  = req_tdata[47:16];
   assign plain_ext  = {{BW{1'b0}}, req_plain};

   assign rounds_eff = (32'(rounds_ff) > MAX_ROUNDS) ? RW'(MAX_ROUNDS) : RW'(rounds_ff);
   assign round_out  = (rnd_ff == '0) ? (blk_ff ^ keyb_ff) : mix_bytes;
   assign res_ext    = {{RSP_TDATA_W{1'b0}}, round_out};
   assign key_raddr  = key_base_ff + KAW'(cnt_ff);

   assign sbox_we = req_accept && (req_op == OP_SBOX);
   assign key_we  = req_accept && (req_op == OP_KEY) && ({1'b0, req_index} < 9'(KEY_DEPTH));

   always_comb begin
      mat_wr.en    = req_accept && (req_op == OP_MATRIX);
      mat_wr.index = req_index;
      mat_wr.data  = req_byte;
   end

   spn_ram #(
      .DEPTH (256),
      .WIDTH (8)
   ) u_sbox (
      .clock   (clock),
      .wr_en   (sbox_we),
      .wr_addr (req_index),
      .wr_data (req_byte),
      .rd_en   (sbox_re),
      .rd_addr (blk_ff[cnt_ff[LW-1:0]]),
      .rd_data (sbox_rdata)
   );

   spn_ram #(
      .DEPTH (KEY_DEPTH),
      .WIDTH (8)
   ) u_keys (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (req_index[KAW-1:0]),
      .wr_data (req_byte),
      .rd_en   (key_re),
      .rd_addr (key_raddr),
      .rd_data (key_rdata)
   );

   spn_mix #(
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_mix (
      .clock     (clock),
      .mat_wr    (mat_wr),
      .sub_bytes (sub_ff),
      .key_bytes (keyb_ff),
      .mix_bytes (mix_bytes)
   );

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      rnd_in      = rnd_ff;
      key_base_in = key_base_ff;
      cap_in      = 1'b0;
      lane_in     = lane_ff;
      blk_in      = blk_ff;
      sub_in      = sub_ff;
      keyb_in     = keyb_ff;
      rsp_data_in = rsp_data_ff;
      rsp_load    = 1'b0;
      sbox_re     = 1'b0;
      key_re      = 1'b0;

      if (cap_ff) begin
         sub_in[lane_ff]  = sbox_rdata;
         keyb_in[lane_ff] = key_rdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_op == OP_ENCRYPT)) begin
               blk_in      = plain_ext[BW-1:0];
               rnd_in      = '0;
               key_base_in = '0;
               cnt_in      = '0;
               state_in    = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (cnt_ff == CW'(BLOCK_BYTES)) begin
               state_in = ST_MIX;
            end else begin
               sbox_re = 1'b1;
               key_re  = 1'b1;
               cap_in  = 1'b1;
               lane_in = cnt_ff[LW-1:0];
               cnt_in  = CW'(cnt_ff + 1'b1);
            end
         end
         ST_MIX: begin
            if (rnd_ff == rounds_eff) begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_load    = 1'b1;
                  rsp_data_in = res_ext[RSP_TDATA_W-1:0];
                  state_in    = ST_IDLE;
               end
            end else begin
               blk_in      = round_out;
               rnd_in      = RW'(rnd_ff + 1'b1);
               key_base_in = KAW'(key_base_ff + KAW'(BLOCK_BYTES));
               cnt_in      = '0;
               state_in    = ST_FETCH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rounds_in    = csr_we ? csr_wdata : rounds_ff;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rounds_ff    <= RESET_ROUNDS;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
         rounds_ff    <= rounds_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      rnd_ff      <= rnd_in;
      key_base_ff <= key_base_in;
      lane_ff     <= lane_in;
      blk_ff      <= blk_in;
      sub_ff      <= sub_in;
      keyb_ff     <= keyb_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### hw/rtl/spn_checker.sv
// Port-level checks for the SPN cipher top level, bound to it below.
// Depends on spn_pkg and spn_block_cipher_table_driven_assert.svh.
`include "spn_block_cipher_table_driven_assert.svh"

module spn_checker
   import spn_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_TUSER_W-1:0] req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   `SPN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")
   `SPN_ASSERT_NEXT(a_busy_after_encrypt, clock, reset, req_tvalid && req_tready && (req_tuser == OP_ENCRYPT), !req_tready, "input ready right after encrypt transfer")
   `SPN_ASSERT_NOW(a_rsp_from_encrypt, clock, reset, $rose(rsp_tvalid), !$past(req_tready), "result appeared without encrypt in progress")

endmodule

bind spn_block_cipher_table_driven spn_checker u_spn_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
